// ----- rtl/tpe_pkg.sv -----
// tpe_pkg: widths, latencies and shared step functions of the triangle plane pipeline
// used by every module of the block; depends on nothing
`default_nettype none

package tpe_pkg;

	localparam int COORD_WIDTH_DEF = 16;

	// scaled cross product magnitudes and their sum of squares
	localparam int M_W = 31;
	localparam int S_W = 64;
	localparam int L_W = 32;

	// integer square root: one result bit per step
	localparam int SQRT_STEPS     = 32;
	localparam int SQRT_PER_STAGE = 2;
	localparam int SQRT_LAT       = SQRT_STEPS / SQRT_PER_STAGE;

	// normal division: quotient bits, numerator shift and remainder width
	localparam int Q_W            = 16;
	localparam int DIV_PER_STAGE  = 2;
	localparam int DIV_LAT        = Q_W / DIV_PER_STAGE;
	localparam int DIV_NUM_SHIFT  = 15;
	localparam int N_W            = M_W + DIV_NUM_SHIFT + 1;
	localparam int R_W            = L_W + 2;

	localparam int CROSS_LAT  = 4;
	localparam int SCALE_LAT  = 5;
	localparam int OFFSET_LAT = 4;
	localparam int LATENCY    = CROSS_LAT + SCALE_LAT + SQRT_LAT + DIV_LAT + OFFSET_LAT;

	localparam int NORM_W      = 16;
	localparam int OFF_W       = 20;
	localparam int Q14_SHIFT   = 14;
	localparam int ROUND_HALF  = 8192;
	localparam logic [Q_W-1:0] ONE_Q14 = 16'd16384;
	localparam int OFF_MAX     = 524287;
	localparam int OFF_MIN     = -524288;

	typedef struct packed {
		logic [S_W-1:0] x;
		logic [S_W-1:0] r;
	} sqrt_state_t;

	typedef struct packed {
		logic [R_W-1:0] rem;
		logic [Q_W-1:0] low;
		logic [Q_W-1:0] q;
	} div_state_t;

	function automatic sqrt_state_t sqrt_step(input sqrt_state_t st, input logic [S_W-1:0] bitv);
		sqrt_state_t nx;
		logic [S_W:0] trial;
		trial = {1'b0, st.r} + {1'b0, bitv};
		if ({1'b0, st.x} >= trial) begin
			nx.x = st.x - trial[S_W-1:0];
			nx.r = (st.r >> 1) + bitv;
		end else begin
			nx.x = st.x;
			nx.r = st.r >> 1;
		end
		return nx;
	endfunction

	function automatic div_state_t div_step(input div_state_t st, input logic [L_W:0] d);
		div_state_t nx;
		logic [R_W-1:0] sh;
		sh = {st.rem[R_W-2:0], st.low[Q_W-1]};
		nx.low = {st.low[Q_W-2:0], 1'b0};
		if (sh >= R_W'(d)) begin
			nx.rem = sh - R_W'(d);
			nx.q   = {st.q[Q_W-2:0], 1'b1};
		end else begin
			nx.rem = sh;
			nx.q   = {st.q[Q_W-2:0], 1'b0};
		end
		return nx;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/triangle_plane_equation.sv -----
// triangle_plane_equation: top level, chains cross, scale, sqrt and divide units
// and forms the plane offset; depends on tpe_pkg and the tpe_* modules
`default_nettype none

// Takes one triangle per clock: a transaction is accepted whenever start is high, and busy
// stays low since every stage advances in every cycle. The unit normal (Q1.14), the plane
// offset (Q19.0, an integer) and the degenerate flag appear on the result ports for one
// cycle with done high; the receiver cannot stall, so results must be taken as they come.
// The latency is set by the 16-stage square root and the 8-stage divider (two result bits
// per stage each) plus 13 stages of cross product, scaling and offset.

module triangle_plane_equation import tpe_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [COORD_WIDTH-1:0] first_x,
	input  logic signed [COORD_WIDTH-1:0] first_y,
	input  logic signed [COORD_WIDTH-1:0] first_z,
	input  logic signed [COORD_WIDTH-1:0] second_x,
	input  logic signed [COORD_WIDTH-1:0] second_y,
	input  logic signed [COORD_WIDTH-1:0] second_z,
	input  logic signed [COORD_WIDTH-1:0] third_x,
	input  logic signed [COORD_WIDTH-1:0] third_y,
	input  logic signed [COORD_WIDTH-1:0] third_z,
	output logic                          done,
	output logic signed [NORM_W-1:0]      normal_x,
	output logic signed [NORM_W-1:0]      normal_y,
	output logic signed [NORM_W-1:0]      normal_z,
	output logic signed [OFF_W-1:0]       plane_offset,
	output logic                          degenerate
);

	localparam int CW        = COORD_WIDTH;
	localparam int MW        = 2 * CW + 2;
	localparam int V1_W      = 3 * CW;
	localparam int SC_SIDE_W = 3 + V1_W;
	localparam int SQ_SIDE_W = 1 + 3 * M_W + SC_SIDE_W;
	localparam int DV_SIDE_W = 1 + SC_SIDE_W;
	localparam int PRW       = CW + NORM_W;
	localparam int UW        = CW + NORM_W + 3;
	localparam int QW        = UW - Q14_SHIFT;

	logic signed [CW-1:0] vert [9];
	logic                 cr_valid;
	logic [MW-1:0]        cr_mag [3];
	logic [2:0]           cr_neg;
	logic [V1_W-1:0]      cr_v1;

	logic                 sc_valid;
	logic [S_W-1:0]       sc_sum;
	logic [3*M_W-1:0]     sc_m;
	logic                 sc_deg;
	logic [SC_SIDE_W-1:0] sc_side;

	logic                 sq_valid;
	logic [L_W-1:0]       sq_root;
	logic [SQ_SIDE_W-1:0] sq_side;

	logic                 dv_valid;
	logic [3*Q_W-1:0]     dv_quot;
	logic [DV_SIDE_W-1:0] dv_side;

	logic                    vld_o1, vld_o2, vld_o3;
	logic signed [NORM_W-1:0] n_o1 [3];
	logic signed [NORM_W-1:0] n_o2 [3];
	logic signed [NORM_W-1:0] n_o3 [3];
	logic signed [PRW-1:0]    prod_o2 [3];
	logic signed [QW-1:0]     q_o3;
	logic                     deg_o1, deg_o2, deg_o3;
	logic [V1_W-1:0]          v1_o1;
	logic signed [UW-1:0]     u_c;
	logic signed [63:0]       qx_c;
	logic [Q_W-1:0]           a_c [3];

	assign busy = 1'b0;

	assign vert[0] = first_x;
	assign vert[1] = first_y;
	assign vert[2] = first_z;
	assign vert[3] = second_x;
	assign vert[4] = second_y;
	assign vert[5] = second_z;
	assign vert[6] = third_x;
	assign vert[7] = third_y;
	assign vert[8] = third_z;

	tpe_cross #(.CW(CW)) u_cross (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.vert      (vert),
		.out_valid (cr_valid),
		.mag       (cr_mag),
		.neg       (cr_neg),
		.v1        (cr_v1)
	);

	tpe_scale #(.CW(CW), .SIDE_W(SC_SIDE_W)) u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cr_valid),
		.mag       (cr_mag),
		.side_in   ({cr_neg, cr_v1}),
		.out_valid (sc_valid),
		.sum_sq    (sc_sum),
		.m_out     (sc_m),
		.deg       (sc_deg),
		.side_out  (sc_side)
	);

	tpe_sqrt #(.SIDE_W(SQ_SIDE_W)) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sc_valid),
		.radicand  (sc_sum),
		.side_in   ({sc_deg, sc_m, sc_side}),
		.out_valid (sq_valid),
		.root      (sq_root),
		.side_out  (sq_side)
	);

	tpe_div #(.SIDE_W(DV_SIDE_W)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sq_valid),
		.m_in      (sq_side[SC_SIDE_W +: 3*M_W]),
		.root      (sq_root),
		.side_in   ({sq_side[SQ_SIDE_W-1], sq_side[SC_SIDE_W-1:0]}),
		.out_valid (dv_valid),
		.quot      (dv_quot),
		.side_out  (dv_side)
	);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			a_c[i] = dv_quot[i*Q_W +: Q_W];
			if (a_c[i] > ONE_Q14) a_c[i] = ONE_Q14;
		end
	end

	// floor((8192 - dot) / 2^14) is the half-up rounding of -dot / 2^14
	assign u_c = UW'(ROUND_HALF) - (UW'(prod_o2[0]) + UW'(prod_o2[1]) + UW'(prod_o2[2]));
	assign qx_c = 64'(q_o3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o1 <= 1'b0;
			vld_o2 <= 1'b0;
			vld_o3 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_o1 <= dv_valid;
			vld_o2 <= vld_o1;
			vld_o3 <= vld_o2;
			done   <= vld_o3;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++)
			n_o1[i] <= dv_side[V1_W+i] ? -NORM_W'(a_c[i]) : NORM_W'(a_c[i]);
		deg_o1 <= dv_side[DV_SIDE_W-1];
		v1_o1  <= dv_side[V1_W-1:0];

		for (int i = 0; i < 3; i++)
			prod_o2[i] <= PRW'(n_o1[i]) * PRW'($signed(v1_o1[i*CW +: CW]));
		n_o2   <= n_o1;
		deg_o2 <= deg_o1;

		q_o3   <= QW'(u_c >>> Q14_SHIFT);
		n_o3   <= n_o2;
		deg_o3 <= deg_o2;

		if (vld_o3) begin
			degenerate <= deg_o3;
			if (deg_o3) begin
				normal_x     <= '0;
				normal_y     <= '0;
				normal_z     <= '0;
				plane_offset <= '0;
			end else begin
				normal_x <= n_o3[0];
				normal_y <= n_o3[1];
				normal_z <= n_o3[2];
				if (qx_c > 64'(OFF_MAX)) plane_offset <= OFF_W'(OFF_MAX);
				else if (qx_c < 64'(OFF_MIN)) plane_offset <= OFF_W'(OFF_MIN);
				else plane_offset <= OFF_W'(qx_c);
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/tpe_cross.sv -----
// tpe_cross: edge vectors, exact cross product, sign and magnitude, four stages
// depends on tpe_pkg
`default_nettype none

module tpe_cross import tpe_pkg::*; #(
	parameter int CW = COORD_WIDTH_DEF,
	localparam int EW = CW + 1,
	localparam int PW = 2 * CW + 2,
	localparam int CXW = 2 * CW + 3,
	localparam int MW = 2 * CW + 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic signed [CW-1:0] vert [9],
	output logic                 out_valid,
	output logic [MW-1:0]        mag [3],
	output logic [2:0]           neg,
	output logic [3*CW-1:0]      v1
);

	logic                 vld_s1, vld_s2, vld_s3, vld_s4;
	logic signed [EW-1:0] e1_s1 [3];
	logic signed [EW-1:0] e2_s1 [3];
	logic signed [PW-1:0] pa_s2 [3];
	logic signed [PW-1:0] pb_s2 [3];
	logic signed [CXW-1:0] c_s3 [3];
	logic [MW-1:0]        mag_s4 [3];
	logic [2:0]           neg_s4;
	logic [3*CW-1:0]      v1_s1, v1_s2, v1_s3, v1_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			e1_s1[i] <= EW'(vert[3+i]) - EW'(vert[i]);
			e2_s1[i] <= EW'(vert[6+i]) - EW'(vert[i]);
		end
		v1_s1 <= {vert[2], vert[1], vert[0]};

		pa_s2[0] <= PW'(e1_s1[1]) * PW'(e2_s1[2]);
		pb_s2[0] <= PW'(e1_s1[2]) * PW'(e2_s1[1]);
		pa_s2[1] <= PW'(e1_s1[2]) * PW'(e2_s1[0]);
		pb_s2[1] <= PW'(e1_s1[0]) * PW'(e2_s1[2]);
		pa_s2[2] <= PW'(e1_s1[0]) * PW'(e2_s1[1]);
		pb_s2[2] <= PW'(e1_s1[1]) * PW'(e2_s1[0]);
		v1_s2 <= v1_s1;

		for (int i = 0; i < 3; i++)
			c_s3[i] <= CXW'(pa_s2[i]) - CXW'(pb_s2[i]);
		v1_s3 <= v1_s2;

		for (int i = 0; i < 3; i++) begin
			neg_s4[i] <= c_s3[i][CXW-1];
			mag_s4[i] <= c_s3[i][CXW-1] ? MW'(-c_s3[i]) : MW'(c_s3[i]);
		end
		v1_s4 <= v1_s3;
	end

	assign out_valid = vld_s4;
	assign mag       = mag_s4;
	assign neg       = neg_s4;
	assign v1        = v1_s4;

endmodule

`default_nettype wire

// ----- rtl/tpe_scale.sv -----
// tpe_scale: common power-of-two scaling to 31 bits and sum of squares, five stages
// depends on tpe_pkg
`default_nettype none

module tpe_scale import tpe_pkg::*; #(
	parameter int CW = COORD_WIDTH_DEF,
	parameter int SIDE_W = 1,
	localparam int MW = 2 * CW + 2,
	localparam int TW = $clog2(MW + 1),
	localparam int EXT_W = MW + M_W
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [MW-1:0]     mag [3],
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_valid,
	output logic [S_W-1:0]    sum_sq,
	output logic [3*M_W-1:0]  m_out,
	output logic              deg,
	output logic [SIDE_W-1:0] side_out
);

	logic              vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [MW-1:0]     or_s1;
	logic [MW-1:0]     mag_s1 [3];
	logic [MW-1:0]     mag_s2 [3];
	logic [TW-1:0]     top_s2;
	logic [TW-1:0]     top_c;
	logic [M_W-1:0]    m_s3 [3];
	logic [M_W-1:0]    m_s4 [3];
	logic [M_W-1:0]    m_s5 [3];
	logic [2*M_W-1:0]  sq_s4 [3];
	logic [S_W-1:0]    sum_s5;
	logic              deg_s3, deg_s4, deg_s5;
	logic [SIDE_W-1:0] side_s1, side_s2, side_s3, side_s4, side_s5;
	logic [EXT_W-1:0]  ext_c [3];

	// bit length of the largest magnitude
	always_comb begin
		top_c = '0;
		for (int i = 0; i < MW; i++)
			if (or_s1[i]) top_c = TW'(i + 1);
	end

	// mag >> (top - 31) written as (mag << 31) >> top
	always_comb begin
		for (int i = 0; i < 3; i++)
			ext_c[i] = {mag_s2[i], {M_W{1'b0}}} >> top_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		or_s1   <= mag[0] | mag[1] | mag[2];
		mag_s1  <= mag;
		side_s1 <= side_in;

		top_s2  <= top_c;
		mag_s2  <= mag_s1;
		side_s2 <= side_s1;

		for (int i = 0; i < 3; i++)
			m_s3[i] <= ext_c[i][M_W-1:0];
		deg_s3  <= (top_s2 == '0);
		side_s3 <= side_s2;

		for (int i = 0; i < 3; i++)
			sq_s4[i] <= (2*M_W)'(m_s3[i]) * (2*M_W)'(m_s3[i]);
		m_s4    <= m_s3;
		deg_s4  <= deg_s3;
		side_s4 <= side_s3;

		sum_s5  <= S_W'(sq_s4[0]) + S_W'(sq_s4[1]) + S_W'(sq_s4[2]);
		m_s5    <= m_s4;
		deg_s5  <= deg_s4;
		side_s5 <= side_s4;
	end

	assign out_valid = vld_s5;
	assign sum_sq    = sum_s5;
	assign m_out     = {m_s5[2], m_s5[1], m_s5[0]};
	assign deg       = deg_s5;
	assign side_out  = side_s5;

endmodule

`default_nettype wire

// ----- rtl/tpe_sqrt.sv -----
// tpe_sqrt: pipelined integer square root of the 64-bit sum, two result bits per stage
// depends on tpe_pkg
`default_nettype none

module tpe_sqrt import tpe_pkg::*; #(
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [S_W-1:0]    radicand,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_valid,
	output logic [L_W-1:0]    root,
	output logic [SIDE_W-1:0] side_out
);

	sqrt_state_t       st_s   [SQRT_LAT];
	logic              vld_s  [SQRT_LAT];
	logic [SIDE_W-1:0] side_s [SQRT_LAT];

	for (genvar j = 0; j < SQRT_LAT; j++) begin : g_stage
		sqrt_state_t       st_in, st_nx;
		logic              vld_in;
		logic [SIDE_W-1:0] side_src;

		if (j == 0) begin : g_first
			assign st_in    = '{x: radicand, r: '0};
			assign vld_in   = in_valid;
			assign side_src = side_in;
		end else begin : g_next
			assign st_in    = st_s[j-1];
			assign vld_in   = vld_s[j-1];
			assign side_src = side_s[j-1];
		end

		// test bit walks down from 2^62 by two places per step
		always_comb begin
			st_nx = st_in;
			for (int k = 0; k < SQRT_PER_STAGE; k++)
				st_nx = sqrt_step(st_nx, S_W'(1) << (S_W - 2 - 2 * (j * SQRT_PER_STAGE + k)));
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[j] <= 1'b0;
			else vld_s[j] <= vld_in;
		end

		always_ff @(posedge clk) begin
			st_s[j]   <= st_nx;
			side_s[j] <= side_src;
		end
	end

	assign out_valid = vld_s[SQRT_LAT-1];
	assign root      = st_s[SQRT_LAT-1].r[L_W-1:0];
	assign side_out  = side_s[SQRT_LAT-1];

endmodule

`default_nettype wire

// ----- rtl/tpe_div.sv -----
// tpe_div: three lanes of pipelined restoring division (m * 2^15 + L) / (2 L)
// depends on tpe_pkg
`default_nettype none

module tpe_div import tpe_pkg::*; #(
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [3*M_W-1:0]  m_in,
	input  logic [L_W-1:0]    root,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_valid,
	output logic [3*Q_W-1:0]  quot,
	output logic [SIDE_W-1:0] side_out
);

	div_state_t        st_s   [DIV_LAT][3];
	logic [L_W:0]      d_s    [DIV_LAT];
	logic              vld_s  [DIV_LAT];
	logic [SIDE_W-1:0] side_s [DIV_LAT];

	for (genvar j = 0; j < DIV_LAT; j++) begin : g_stage
		div_state_t        st_in [3];
		div_state_t        st_nx [3];
		logic [L_W:0]      d_in;
		logic              vld_in;
		logic [SIDE_W-1:0] side_src;

		if (j == 0) begin : g_first
			logic [N_W-1:0] num [3];
			for (genvar k = 0; k < 3; k++) begin : g_lane
				// quotient stays below 2^16, so the top part starts below the divisor
				assign num[k] = N_W'({m_in[k*M_W +: M_W], {DIV_NUM_SHIFT{1'b0}}})
				              + N_W'(root);
				assign st_in[k] = '{rem: R_W'(num[k][N_W-1:Q_W]), low: num[k][Q_W-1:0],
				                    q: '0};
			end
			assign d_in     = {root, 1'b0};
			assign vld_in   = in_valid;
			assign side_src = side_in;
		end else begin : g_next
			assign st_in    = st_s[j-1];
			assign d_in     = d_s[j-1];
			assign vld_in   = vld_s[j-1];
			assign side_src = side_s[j-1];
		end

		always_comb begin
			for (int k = 0; k < 3; k++) begin
				st_nx[k] = st_in[k];
				for (int b = 0; b < DIV_PER_STAGE; b++)
					st_nx[k] = div_step(st_nx[k], d_in);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[j] <= 1'b0;
			else vld_s[j] <= vld_in;
		end

		always_ff @(posedge clk) begin
			st_s[j]   <= st_nx;
			d_s[j]    <= d_in;
			side_s[j] <= side_src;
		end
	end

	assign out_valid = vld_s[DIV_LAT-1];
	assign quot      = {st_s[DIV_LAT-1][2].q, st_s[DIV_LAT-1][1].q, st_s[DIV_LAT-1][0].q};
	assign side_out  = side_s[DIV_LAT-1];

endmodule

`default_nettype wire

// ----- rtl/tpe_checker.sv -----
// tpe_checker: port-level assertions on the triangle plane pipeline, bound to the top
// depends on tpe_pkg and triangle_plane_equation
`default_nettype none

module tpe_checker import tpe_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     start,
	input logic                     busy,
	input logic                     done,
	input logic signed [NORM_W-1:0] normal_x,
	input logic signed [NORM_W-1:0] normal_y,
	input logic signed [NORM_W-1:0] normal_z,
	input logic signed [OFF_W-1:0]  plane_offset,
	input logic                     degenerate
);

	// the pipeline never holds off a transaction
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LATENCY done)
		else $error("result missing after fixed latency");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LATENCY))
		else $error("result without a matching transaction");

	a_degenerate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && degenerate) |-> (normal_x == 0 && normal_y == 0 && normal_z == 0
		&& plane_offset == 0))
		else $error("degenerate result not zero");

	a_normal_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !degenerate) |-> (normal_x <= 16384 && normal_x >= -16384
		&& normal_y <= 16384 && normal_y >= -16384
		&& normal_z <= 16384 && normal_z >= -16384))
		else $error("normal component out of range");

endmodule

bind triangle_plane_equation tpe_checker u_tpe_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.normal_x     (normal_x),
	.normal_y     (normal_y),
	.normal_z     (normal_z),
	.plane_offset (plane_offset),
	.degenerate   (degenerate)
);

`default_nettype wire
